>>> design/wtqs_pkg.sv
`default_nettype none

package wtqs_pkg;

   localparam int unsigned DEF_QUEUE_DEPTH = 256;

   localparam int unsigned VALUE_W    = 32;
   localparam int unsigned CAP_W      = 9;
   localparam int unsigned WEIGHT_W   = 8;
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned REG_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [REG_IDX_W-1:0] REG_NORMAL_CAP   = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_PRIORITY_CAP = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_WEIGHT       = 2'd2;

   localparam logic KIND_ENQ = 1'b0;
   localparam logic KIND_DEQ = 1'b1;

   localparam logic [CAP_W-1:0]    CAP_RESET    = 9'd256;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 8'd2;

   typedef struct packed {
      logic enq;
      logic deq;
      logic capture;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

>>> design/wtqs_ram.sv
`default_nettype none

module wtqs_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> design/wtqs_ctrl.sv
`default_nettype none

module wtqs_ctrl
   import wtqs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic       req_kind,
   input  wire status_type status,
   output cmd_type         cmd
);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_READ    = 2'd1;
   localparam logic [1:0] ST_DELIVER = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd          = '0;
      cmd.enq      = accept && (req_kind == KIND_ENQ);
      cmd.deq      = accept && (req_kind == KIND_DEQ);
      cmd.capture  = (state_ff == ST_READ);
      cmd.load_out = (state_ff == ST_DELIVER) && status.out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.enq) begin
               state_in = ST_DELIVER;
            end else if (cmd.deq) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_DELIVER;
         end
         ST_DELIVER: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("transaction accepted but controller stayed idle");

   a_read_then_deliver: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_DELIVER))
      else $error("read data not captured in the following cycle");

   a_deliver_waits: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DELIVER) && !status.out_free) |=> (state_ff == ST_DELIVER))
      else $error("result left before the output register was free");

endmodule

`default_nettype wire

>>> design/wtqs_dp.sv
`default_nettype none

module wtqs_dp
   import wtqs_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output status_type                 status,
   input  wire logic [VALUE_W-1:0]    req_value,
   input  wire logic                  req_priority,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   input  wire logic                  rsp_tready,
   output logic                       rsp_tvalid,
   output logic                       rsp_ok,
   output logic                       rsp_served_priority,
   output logic      [VALUE_W-1:0]    rsp_served_value
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned SUM_W = CNT_W + 1;
   localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam logic [CAP_W-1:0] CAP_INIT =
      (QUEUE_DEPTH < 256) ? CAP_W'(QUEUE_DEPTH) : CAP_RESET;

   function automatic logic [CAP_W-1:0] clamp_cap(input logic [CAP_W-1:0] v);
      if (32'(v) > QUEUE_DEPTH) begin
         clamp_cap = CAP_W'(QUEUE_DEPTH);
      end else begin
         clamp_cap = v;
      end
   endfunction

   function automatic logic [PTR_W-1:0] tail_of(input logic [PTR_W-1:0] head,
                                                input logic [CNT_W-1:0] count);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(head) + SUM_W'(count);
      if (sum >= SUM_W'(QUEUE_DEPTH)) begin
         sum = sum - SUM_W'(QUEUE_DEPTH);
      end
      tail_of = sum[PTR_W-1:0];
   endfunction

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         bump = '0;
      end else begin
         bump = p + PTR_W'(1);
      end
   endfunction

   // configuration registers
   logic [CAP_W-1:0]    n_cap_ff, p_cap_ff;
   logic [WEIGHT_W-1:0] weight_ff;
   logic                csr_wr;
   logic [REG_IDX_W-1:0] reg_idx;

   // queue state
   logic [PTR_W-1:0]    n_head_ff, n_head_in, p_head_ff, p_head_in;
   logic [CNT_W-1:0]    n_count_ff, n_count_in, p_count_ff, p_count_in;
   logic [WEIGHT_W-1:0] sc_ff, sc_in;

   // pending result and output register
   logic               pend_ok_ff, pend_ok_in, pend_pri_ff, pend_pri_in;
   logic [VALUE_W-1:0] pend_value_ff, pend_value_in;
   logic               out_valid_ff, out_valid_in;
   logic               out_ok_ff, out_pri_ff;
   logic [VALUE_W-1:0] out_value_ff;

   logic               n_full, p_full, n_empty, p_empty;
   logic               prefer_normal, take_norm, take_pri;
   logic [WEIGHT_W-1:0] w_eff;
   logic [WEIGHT_W:0]  sc_inc;
   logic               n_we, p_we;
   logic [VALUE_W-1:0] n_rdata, p_rdata;

   assign reg_idx = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_wr  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         n_cap_ff  <= CAP_INIT;
         p_cap_ff  <= CAP_INIT;
         weight_ff <= WEIGHT_RESET;
      end else if (csr_wr) begin
         unique case (reg_idx)
            REG_NORMAL_CAP:   n_cap_ff  <= clamp_cap(csr_pwdata[CAP_W-1:0]);
            REG_PRIORITY_CAP: p_cap_ff  <= clamp_cap(csr_pwdata[CAP_W-1:0]);
            REG_WEIGHT:       weight_ff <= csr_pwdata[WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_NORMAL_CAP:   csr_prdata = CSR_DATA_W'(n_cap_ff);
         REG_PRIORITY_CAP: csr_prdata = CSR_DATA_W'(p_cap_ff);
         REG_WEIGHT:       csr_prdata = CSR_DATA_W'(weight_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign n_full  = CMP_W'(n_count_ff) >= CMP_W'(n_cap_ff);
   assign p_full  = CMP_W'(p_count_ff) >= CMP_W'(p_cap_ff);
   assign n_empty = (n_count_ff == '0);
   assign p_empty = (p_count_ff == '0);

   // service count always stays below the effective weight
   assign prefer_normal = (sc_ff == '0);
   assign take_norm = prefer_normal ? !n_empty : (p_empty && !n_empty);
   assign take_pri  = prefer_normal ? (n_empty && !p_empty) : !p_empty;
   assign w_eff     = (weight_ff == '0) ? WEIGHT_W'(1) : weight_ff;
   assign sc_inc    = {1'b0, sc_ff} + (WEIGHT_W + 1)'(1);

   assign n_we = cmd.enq && !req_priority && !n_full;
   assign p_we = cmd.enq && req_priority && !p_full;

   always_comb begin
      n_head_in     = n_head_ff;
      p_head_in     = p_head_ff;
      n_count_in    = n_count_ff;
      p_count_in    = p_count_ff;
      sc_in         = sc_ff;
      pend_ok_in    = pend_ok_ff;
      pend_pri_in   = pend_pri_ff;
      pend_value_in = pend_value_ff;
      if (n_we) begin
         n_count_in = n_count_ff + CNT_W'(1);
      end
      if (p_we) begin
         p_count_in = p_count_ff + CNT_W'(1);
      end
      if (cmd.enq) begin
         pend_ok_in    = n_we || p_we;
         pend_pri_in   = 1'b0;
         pend_value_in = '0;
      end
      if (cmd.deq) begin
         if (take_norm) begin
            n_head_in  = bump(n_head_ff);
            n_count_in = n_count_ff - CNT_W'(1);
         end
         if (take_pri) begin
            p_head_in  = bump(p_head_ff);
            p_count_in = p_count_ff - CNT_W'(1);
         end
         pend_ok_in  = take_norm || take_pri;
         pend_pri_in = take_pri;
         sc_in = (sc_inc >= {1'b0, w_eff}) ? '0 : sc_inc[WEIGHT_W-1:0];
      end
      if (cmd.capture) begin
         if (!pend_ok_ff) begin
            pend_value_in = '0;
         end else if (pend_pri_ff) begin
            pend_value_in = p_rdata;
         end else begin
            pend_value_in = n_rdata;
         end
      end
      if (csr_wr && (reg_idx == REG_WEIGHT)) begin
         sc_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_head_ff  <= '0;
         p_head_ff  <= '0;
         n_count_ff <= '0;
         p_count_ff <= '0;
         sc_ff      <= '0;
      end else begin
         n_head_ff  <= n_head_in;
         p_head_ff  <= p_head_in;
         n_count_ff <= n_count_in;
         p_count_ff <= p_count_in;
         sc_ff      <= sc_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ok_ff    <= pend_ok_in;
      pend_pri_ff   <= pend_pri_in;
      pend_value_ff <= pend_value_in;
      if (cmd.load_out) begin
         out_ok_ff    <= pend_ok_ff;
         out_pri_ff   <= pend_pri_ff;
         out_value_ff <= pend_value_ff;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign status.out_free     = !out_valid_ff || rsp_tready;
   assign rsp_tvalid          = out_valid_ff;
   assign rsp_ok              = out_ok_ff;
   assign rsp_served_priority = out_pri_ff;
   assign rsp_served_value    = out_value_ff;

   wtqs_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_normal_ram (
      .clock(clock),
      .we   (n_we),
      .waddr(tail_of(n_head_ff, n_count_ff)),
      .wdata(req_value),
      .re   (cmd.deq),
      .raddr(n_head_ff),
      .rdata(n_rdata)
   );

   wtqs_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_priority_ram (
      .clock(clock),
      .we   (p_we),
      .waddr(tail_of(p_head_ff, p_count_ff)),
      .wdata(req_value),
      .re   (cmd.deq),
      .raddr(p_head_ff),
      .rdata(p_rdata)
   );

   a_counts_in_range: assert property (@(posedge clock) disable iff (reset)
      (SUM_W'(n_count_ff) <= SUM_W'(QUEUE_DEPTH)) &&
      (SUM_W'(p_count_ff) <= SUM_W'(QUEUE_DEPTH)))
      else $error("queue fill count beyond depth");

   a_service_below_weight: assert property (@(posedge clock) disable iff (reset)
      (sc_ff == '0) || (sc_ff < weight_ff))
      else $error("service count not below weight");

   a_failed_result_clean: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ok_ff) |-> (!out_pri_ff && (out_value_ff == '0)))
      else $error("failed transaction carries served data");

endmodule

`default_nettype wire

>>> design/weighted_two_queue_scheduler_core.sv
// Weighted scheduler over a normal and a priority queue.
// Request stream (req_*): tuser[0] = kind (0 enqueue, 1 dequeue),
// tuser[1] = queue select for enqueue, tdata = value to enqueue.
// Response stream (rsp_*): one transaction per request, tuser[0] = ok,
// tuser[1] = served from priority queue, tdata = served value (0 unless a
// dequeue succeeded). Responses come out in request order.
// An accepted enqueue goes from the DELIVER state into the output register;
// a dequeue first passes READ, which captures the registered memory read.
// One request is in flight at a time: the next one is accepted only once
// the previous result has been loaded into the output register.
// The response sits in an output register; a new request is accepted while
// it waits, and the next result is held back until that register drains.
// A stalled receiver therefore stalls req_tready after at most one request.
// Configuration (csr_*): capacities at 0x0 and 0x4, weight at 0x8; write only
// while idle. Writing the weight restarts the service rotation.
// Reset empties both queues and restores capacity 256 (or the queue depth if
// smaller) and weight 2; memory contents are not cleared and need no sweep.
`default_nettype none

module weighted_two_queue_scheduler_core
   import wtqs_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [VALUE_W-1:0]    req_tdata,   // [31:0] value
   input  wire logic [1:0]            req_tuser,   // [0] kind, [1] priority_req
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [VALUE_W-1:0]    rsp_tdata,   // [31:0] served_value
   output logic      [1:0]            rsp_tuser,   // [0] ok, [1] served_priority
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   cmd_type    cmd;
   status_type status;
   logic       rsp_ok, rsp_pri;

   assign csr_pready = 1'b1;

   wtqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_kind  (req_tuser[0]),
      .status    (status),
      .cmd       (cmd)
   );

   wtqs_dp #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_value          (req_tdata),
      .req_priority       (req_tuser[1]),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .rsp_tready         (rsp_tready),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_ok             (rsp_ok),
      .rsp_served_priority(rsp_pri),
      .rsp_served_value   (rsp_tdata)
   );

   assign rsp_tuser = {rsp_pri, rsp_ok};

endmodule

`default_nettype wire
